// ===== rtl/smi_pkg.sv =====
// Shared constants for the servo move interpolator.
// Used by smi_div, servo_move_interpolator and the testbench; depends on nothing.
package smi_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int ANGLE_W       = 8;
    localparam int TIME_W        = 16;
    localparam int FINE_W        = 16;

    localparam logic [ANGLE_W-1:0] MAX_ANGLE = 8'd180;

    localparam logic [1:0] OP_TICK         = 2'd0;
    localparam logic [1:0] OP_SET_TARGET   = 2'd1;
    localparam logic [1:0] OP_SET_POSITION = 2'd2;

endpackage

// ===== rtl/smi_div.sv =====
// Restoring serial divider: one quotient bit per cycle.
// Depends on smi_pkg for the default divisor width.
module smi_div #(
    parameter int QUO_W = 16,
    parameter int DEN_W = smi_pkg::TIME_W
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [QUO_W+DEN_W-1:0] dividend,
    input  logic [DEN_W-1:0]       divisor,
    output logic                   done,
    output logic [QUO_W-1:0]       quotient
);
    import smi_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] shift_reg, shift_next;
    logic [DEN_W-1:0] divisor_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_sub;
    logic             ge;

    // The upper dividend half is below the divisor, so the quotient fits QUO_W bits.
    always_comb
    begin
        trial      = {rem_reg, shift_reg[QUO_W-1]};
        ge         = trial >= {1'b0, divisor_reg};
        trial_sub  = trial - {1'b0, divisor_reg};
        rem_next   = rem_reg;
        shift_next = shift_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            rem_next   = dividend[QUO_W+DEN_W-1:QUO_W];
            shift_next = dividend[QUO_W-1:0];
            count_next = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next   = ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            shift_next = {shift_reg[QUO_W-2:0], ge};
            if (count_reg == CNT_W'(QUO_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
        if (start)
        begin
            divisor_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = shift_reg;

endmodule

// ===== rtl/servo_move_interpolator.sv =====
// Servo move interpolator: a linear position ramp driven by timed ticks.
// A tick that takes a partial step does one multiply, then a serial divide by the move
// duration in smi_div at one quotient bit per cycle over the 8 + FRAC_BITS position bits.
// Set target, set position, a finishing jump, an idle tick and an unused code skip the divide.
// One transaction is worked at a time; in_stall is high until its result is registered,
// and the result waits in an output register while out_stall is high.
// Depends on smi_pkg and smi_div.
module servo_move_interpolator #(
    parameter int FRAC_BITS = smi_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    operation,
    input  logic [smi_pkg::TIME_W-1:0]    elapsed_ms,
    input  logic [smi_pkg::ANGLE_W-1:0]   angle_deg,
    input  logic [smi_pkg::TIME_W-1:0]    move_duration_ms,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [smi_pkg::ANGLE_W-1:0]   drive_angle,
    output logic [smi_pkg::FINE_W-1:0]    fine_position,
    output logic                          moving,
    output logic                          write_strobe
);
    import smi_pkg::*;

    localparam int POS_W  = ANGLE_W + FRAC_BITS;
    localparam int PROD_W = POS_W + TIME_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]         state_reg, state_next;

    logic [1:0]         op_reg;
    logic [TIME_W-1:0]  elapsed_reg;
    logic [ANGLE_W-1:0] angle_reg;
    logic [TIME_W-1:0]  dur_in_reg;

    logic [POS_W-1:0]   cur_pos_reg, cur_pos_next;
    logic [POS_W-1:0]   start_pos_reg, start_pos_next;
    logic [ANGLE_W-1:0] target_reg, target_next;
    logic               tvalid_reg, tvalid_next;
    logic [TIME_W-1:0]  duration_reg, duration_next;
    logic               neg_reg, neg_next;
    logic [PROD_W-1:0]  product_reg, product_next;
    logic               moving_reg, moving_next;
    logic               strobe_reg, strobe_next;

    logic               out_valid_reg, out_valid_next;
    logic [ANGLE_W-1:0] drive_angle_reg;
    logic [FINE_W-1:0]  fine_reg;
    logic               out_moving_reg;
    logic               out_strobe_reg;

    logic [POS_W-1:0]   tgt_pos;
    logic [POS_W-1:0]   angle_pos;
    logic               neg_dir;
    logic [POS_W-1:0]   mag;
    logic [POS_W:0]     pos_sum;
    logic [POS_W:0]     pos_diff;
    logic [31:0]        pos_ext;
    logic               load_out;
    logic               accept;
    logic               div_start;
    logic               div_done;
    logic [POS_W-1:0]   step;

    assign tgt_pos   = {target_reg, {FRAC_BITS{1'b0}}};
    assign angle_pos = {angle_reg, {FRAC_BITS{1'b0}}};
    assign neg_dir   = start_pos_reg > tgt_pos;
    assign mag       = neg_dir ? (start_pos_reg - tgt_pos) : (tgt_pos - start_pos_reg);
    assign pos_sum   = {1'b0, cur_pos_reg} + {1'b0, step};
    assign pos_diff  = {1'b0, cur_pos_reg} - {1'b0, step};
    assign pos_ext   = 32'(cur_pos_reg);

    assign in_stall  = state_reg != S_IDLE;
    assign accept    = in_valid && !in_stall;
    assign div_start = state_reg == S_START;
    assign load_out  = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    smi_div #(
        .QUO_W (POS_W),
        .DEN_W (TIME_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product_reg),
        .divisor  (duration_reg),
        .done     (div_done),
        .quotient (step)
    );

    always_comb
    begin
        state_next     = state_reg;
        cur_pos_next   = cur_pos_reg;
        start_pos_next = start_pos_reg;
        target_next    = target_reg;
        tvalid_next    = tvalid_reg;
        duration_next  = duration_reg;
        neg_next       = neg_reg;
        product_next   = product_reg;
        moving_next    = moving_reg;
        strobe_next    = strobe_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                moving_next = 1'b0;
                strobe_next = 1'b0;
                state_next  = S_OUT;
                case (op_reg)
                    OP_SET_TARGET:
                    begin
                        if (angle_reg <= MAX_ANGLE)
                        begin
                            start_pos_next = cur_pos_reg;
                            target_next    = angle_reg;
                            duration_next  = dur_in_reg;
                            tvalid_next    = 1'b1;
                        end
                    end
                    OP_SET_POSITION:
                    begin
                        if (angle_reg <= MAX_ANGLE && cur_pos_reg != angle_pos)
                        begin
                            cur_pos_next = angle_pos;
                            moving_next  = 1'b1;
                            strobe_next  = 1'b1;
                        end
                    end
                    OP_TICK:
                    begin
                        if (tvalid_reg && cur_pos_reg != tgt_pos)
                        begin
                            if (elapsed_reg >= duration_reg)
                            begin
                                cur_pos_next = tgt_pos;
                                strobe_next  = 1'b1;
                            end
                            else
                            begin
                                neg_next     = neg_dir;
                                product_next = mag * elapsed_reg;
                                state_next   = S_START;
                            end
                        end
                    end
                    default:
                    begin
                        // unused operation code: drop it, report the position unchanged
                        state_next = S_OUT;
                    end
                endcase
            end
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_done)
                begin
                    moving_next = 1'b1;
                    strobe_next = 1'b1;
                    state_next  = S_OUT;
                    // clamp a non-zero step that reaches or passes the target
                    if (neg_reg)
                    begin
                        if (step != '0 && (pos_diff[POS_W] || pos_diff[POS_W-1:0] <= tgt_pos))
                        begin
                            cur_pos_next = tgt_pos;
                        end
                        else
                        begin
                            cur_pos_next = pos_diff[POS_W-1:0];
                        end
                    end
                    else
                    begin
                        if (step != '0 && pos_sum >= {1'b0, tgt_pos})
                        begin
                            cur_pos_next = tgt_pos;
                        end
                        else
                        begin
                            cur_pos_next = pos_sum[POS_W-1:0];
                        end
                    end
                end
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_pos_reg   <= '0;
            start_pos_reg <= '0;
            target_reg    <= '0;
            tvalid_reg    <= 1'b0;
            duration_reg  <= TIME_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_pos_reg   <= cur_pos_next;
            start_pos_reg <= start_pos_next;
            target_reg    <= target_next;
            tvalid_reg    <= tvalid_next;
            duration_reg  <= duration_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= operation;
            elapsed_reg <= elapsed_ms;
            angle_reg   <= angle_deg;
            dur_in_reg  <= move_duration_ms;
        end
        neg_reg     <= neg_next;
        product_reg <= product_next;
        moving_reg  <= moving_next;
        strobe_reg  <= strobe_next;
        if (load_out)
        begin
            drive_angle_reg <= cur_pos_reg[POS_W-1:FRAC_BITS];
            fine_reg        <= pos_ext[FINE_W-1:0];
            out_moving_reg  <= moving_reg;
            out_strobe_reg  <= strobe_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign drive_angle   = drive_angle_reg;
    assign fine_position = fine_reg;
    assign moving        = out_moving_reg;
    assign write_strobe  = out_strobe_reg;

endmodule

// ===== tb/tb.sv =====
// Testbench for servo_move_interpolator: a scoreboard class predicts every result of the ramp
// and checks it, while plain tasks drive random and directed transactions under stalls.
// Depends on smi_pkg and the servo_move_interpolator RTL.

typedef struct {
    logic [7:0]  angle;
    logic [15:0] fine;
    logic        moving;
    logic        strobe;
} servo_report_t;

class servo_ramp_scoreboard;
    localparam int FRAC = smi_pkg::FRAC_BITS_DEF;

    logic [31:0]   cur_pos;
    logic [31:0]   start_pos;
    logic [7:0]    tgt_angle;
    logic          tgt_valid;
    logic [15:0]   dur;
    servo_report_t expected_reports[$];
    int            mismatches;

    function new();
        cur_pos    = 0;
        start_pos  = 0;
        tgt_angle  = 0;
        tgt_valid  = 0;
        dur        = 1;
        mismatches = 0;
    endfunction

    function logic [31:0] to_fixed(logic [7:0] deg);
        return {24'd0, deg} << FRAC;
    endfunction

    function int pending();
        return expected_reports.size();
    endfunction

    // Advance the ramp by one accepted transaction and queue the report it causes.
    function void note_command(logic [1:0] op, logic [15:0] elapsed, logic [7:0] angle,
                               logic [15:0] dur_in);
        servo_report_t r;
        logic [31:0]   tgt_fix;
        logic [63:0]   mag;
        logic [63:0]   stepm;
        longint        pos;
        longint        t;
        bit            neg;
        r.moving = 1'b0;
        r.strobe = 1'b0;
        case (op)
            smi_pkg::OP_SET_TARGET:
            begin
                if (angle <= smi_pkg::MAX_ANGLE)
                begin
                    start_pos = cur_pos;
                    tgt_angle = angle;
                    dur       = dur_in;
                    tgt_valid = 1'b1;
                end
            end
            smi_pkg::OP_SET_POSITION:
            begin
                if (angle <= smi_pkg::MAX_ANGLE && cur_pos != to_fixed(angle))
                begin
                    cur_pos  = to_fixed(angle);
                    r.moving = 1'b1;
                    r.strobe = 1'b1;
                end
            end
            smi_pkg::OP_TICK:
            begin
                tgt_fix = to_fixed(tgt_angle);
                if (tgt_valid && cur_pos != tgt_fix)
                begin
                    if (elapsed >= dur)
                    begin
                        cur_pos  = tgt_fix;
                        r.strobe = 1'b1;
                    end
                    else
                    begin
                        neg   = start_pos > tgt_fix;
                        mag   = neg ? 64'(start_pos - tgt_fix) : 64'(tgt_fix - start_pos);
                        stepm = (mag * 64'(elapsed)) / 64'(dur);
                        pos   = longint'(cur_pos);
                        t     = longint'(tgt_fix);
                        // clamp any overshoot onto the target
                        if (neg)
                        begin
                            pos = pos - longint'(stepm);
                            if (stepm > 0 && pos <= t)
                                pos = t;
                        end
                        else
                        begin
                            pos = pos + longint'(stepm);
                            if (stepm > 0 && pos >= t)
                                pos = t;
                        end
                        cur_pos  = pos[31:0];
                        r.moving = 1'b1;
                        r.strobe = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.angle = 8'((cur_pos >> FRAC) & 32'hFF);
        r.fine  = cur_pos[15:0];
        expected_reports.push_back(r);
    endfunction

    function void check_report(logic [7:0] angle, logic [15:0] fine, logic moving,
                               logic strobe);
        servo_report_t r;
        if (expected_reports.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: angle %0d fine %0d moving %0b strobe %0b",
                         angle, fine, moving, strobe);
            return;
        end
        r = expected_reports.pop_front();
        if (angle !== r.angle || fine !== r.fine || moving !== r.moving
            || strobe !== r.strobe)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch: expected angle %0d fine %0d moving %0b strobe %0b,",
                          " got angle %0d fine %0d moving %0b strobe %0b"},
                         r.angle, r.fine, r.moving, r.strobe, angle, fine, moving, strobe);
        end
    endfunction
endclass

module tb;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  operation;
    logic [15:0] elapsed_ms;
    logic [7:0]  angle_deg;
    logic [15:0] move_duration_ms;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  drive_angle;
    logic [15:0] fine_position;
    logic        moving;
    logic        write_strobe;

    servo_ramp_scoreboard sb;
    int burst_left;
    int hold_requests;

    servo_move_interpolator dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .elapsed_ms       (elapsed_ms),
        .angle_deg        (angle_deg),
        .move_duration_ms (move_duration_ms),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .drive_angle      (drive_angle),
        .fine_position    (fine_position),
        .moving           (moving),
        .write_strobe     (write_strobe)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Offer one transaction, hold it until accepted, then insert a burst gap if due.
    task automatic send_item(logic [1:0] op, logic [15:0] el, logic [7:0] ang,
                             logic [15:0] dur);
        int gap;
        in_valid         <= 1'b1;
        operation        <= op;
        elapsed_ms       <= el;
        angle_deg        <= ang;
        move_duration_ms <= dur;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_command(op, el, ang, dur);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        send_item(smi_pkg::OP_TICK, 16'hFFFF, 8'hFF, 16'hFFFF);
        send_item(smi_pkg::OP_SET_POSITION, 16'h0000, 8'd180, 16'h0000);
        send_item(smi_pkg::OP_SET_POSITION, 16'hFFFF, 8'd180, 16'hFFFF);
        send_item(smi_pkg::OP_SET_POSITION, 16'h0000, 8'd0, 16'h0000);
        send_item(smi_pkg::OP_SET_POSITION, 16'h0000, 8'd181, 16'h0000);
        send_item(smi_pkg::OP_SET_POSITION, 16'hFFFF, 8'd255, 16'hFFFF);
        send_item(smi_pkg::OP_SET_TARGET, 16'h0000, 8'd255, 16'h0000);
        send_item(OP_UNUSED, 16'hFFFF, 8'hFF, 16'hFFFF);
        // zero duration: the tick jumps straight to the target
        send_item(smi_pkg::OP_SET_TARGET, 16'hFFFF, 8'd180, 16'h0000);
        send_item(smi_pkg::OP_TICK, 16'h0000, 8'h00, 16'h0000);
        send_item(smi_pkg::OP_TICK, 16'h0001, 8'h00, 16'h0000);
        // longest ramp: a one millisecond step truncates to nothing
        send_item(smi_pkg::OP_SET_TARGET, 16'h0000, 8'd0, 16'hFFFF);
        send_item(smi_pkg::OP_TICK, 16'h0001, 8'h00, 16'h0000);
        send_item(smi_pkg::OP_TICK, 16'hFFFE, 8'h00, 16'h0000);
        send_item(smi_pkg::OP_TICK, 16'hFFFF, 8'h00, 16'h0000);
        // rising ramp that overshoots on the last step
        send_item(smi_pkg::OP_SET_TARGET, 16'h0000, 8'd90, 16'd10);
        repeat (5) send_item(smi_pkg::OP_TICK, 16'd3, 8'h00, 16'h0000);
        // falling ramp that overshoots below the target
        send_item(smi_pkg::OP_SET_POSITION, 16'h0000, 8'd180, 16'h0000);
        send_item(smi_pkg::OP_SET_TARGET, 16'h0000, 8'd0, 16'd7);
        repeat (3) send_item(smi_pkg::OP_TICK, 16'd3, 8'h00, 16'h0000);
    endtask

    task automatic run_random(int n_items);
        int          sent;
        int          choice;
        int          ticks;
        logic [15:0] dur;
        logic [15:0] el;
        sent = 0;
        while (sent < n_items)
        begin
            choice = $urandom_range(0, 99);
            if (choice < 70)
            begin
                choice = $urandom_range(0, 9);
                if (choice < 7)
                    dur = 16'($urandom_range(1, 40));
                else if (choice == 7)
                    dur = 16'd0;
                else if (choice == 8)
                    dur = 16'($urandom_range(41, 65535));
                else
                    dur = 16'($urandom_range(1, 3));
                send_item(smi_pkg::OP_SET_TARGET, 16'($urandom()),
                          8'($urandom_range(0, 180)), dur);
                sent++;
                ticks = $urandom_range(1, 8);
                repeat (ticks)
                begin
                    choice = $urandom_range(0, 9);
                    if (choice < 7)
                        el = 16'($urandom_range(0, int'(dur) / 3 + 1));
                    else if (choice < 9)
                        el = 16'($urandom_range(int'(dur), 65535));
                    else
                        el = 16'($urandom());
                    send_item(smi_pkg::OP_TICK, el, 8'($urandom()), 16'($urandom()));
                    sent++;
                end
                // sometimes ask for the position that is already held
                if ($urandom_range(0, 4) == 0)
                begin
                    send_item(smi_pkg::OP_SET_POSITION, 16'($urandom()),
                              8'(sb.cur_pos >> smi_pkg::FRAC_BITS_DEF), 16'($urandom()));
                    sent++;
                end
            end
            else if (choice < 82)
            begin
                send_item(smi_pkg::OP_SET_POSITION, 16'($urandom()),
                          8'($urandom_range(0, 180)), 16'($urandom()));
                sent++;
            end
            else
            begin
                send_item(2'($urandom_range(0, 3)), 16'($urandom()), 8'($urandom()),
                          16'($urandom()));
                sent++;
            end
        end
    endtask

    // Receiver: check each accepted result, then choose the next stall level.
    initial
    begin
        int hold_seen;
        int hold_left;
        int mode;
        int mode_left;
        out_stall = 1'b0;
        hold_seen = 0;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                sb.check_report(drive_angle, fine_position, moving, write_strobe);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = 300;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 96);
            end
            else
                mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= 1'($urandom_range(0, 1));
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
        end
    end

    initial
    begin
        sb               = new();
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        operation        = smi_pkg::OP_TICK;
        elapsed_ms       = 16'd0;
        angle_deg        = 8'd0;
        move_duration_ms = 16'd0;
        burst_left       = 0;
        hold_requests    = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        wait_drained();
        run_random(150);
        // hold the receiver off while the sender keeps offering
        hold_requests <= hold_requests + 1;
        run_random(100);
        wait_drained();
        run_random(150);
        wait_drained();
        repeat (40) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
